// File: hw/rtl/bmhq_pkg.sv
// Shared types, constants and codes of the binary min-heap priority queue.
// No dependencies; used by the controller, the datapath, the top level and the checker.
package bmhq_pkg;

	localparam int CAPACITY  = 4096;
	localparam int KEY_BITS  = 32;
	localparam int ID_BITS   = 16;
	localparam int ADDR_BITS = $clog2(CAPACITY);
	localparam int CNT_BITS  = $clog2(CAPACITY + 1);
	// Child indexes 2p+1 and 2p+2 need two more bits than a heap address.
	localparam int CHILD_BITS = ADDR_BITS + 2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [ID_BITS-1:0]  id;
	} entry_t;

	// Result word, first field in the highest bits.
	typedef struct packed {
		logic                is_empty;
		logic [CNT_BITS-1:0] entry_count;
		logic [KEY_BITS-1:0] top_key;
		logic [ID_BITS-1:0]  top_id;
		logic [KEY_BITS-1:0] popped_key;
		logic [ID_BITS-1:0]  popped_id;
	} result_t;

	localparam int RES_BITS   = $bits(result_t);
	localparam int OUT_TDATA_BITS = ((RES_BITS + 7) / 8) * 8;
	localparam int IN_TDATA_BITS  = ((KEY_BITS + ID_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_POP_RD,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_FIN
	} bmhq_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic flag_empty;
		logic flag_full;
		logic ins_init;
		logic pop_init;
		logic pop_load;
		logic up_read;
		logic up_step;
		logic down_read;
		logic down_step;
		logic place;
		logic load_out;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_pop;
		logic heap_empty;
		logic single;
		logic full;
		logic at_root;
		logic up_swap;
		logic down_leaf;
		logic down_move;
		logic out_busy;
	} dp_stat_t;

endpackage

// File: hw/rtl/bmhq_ctrl.sv
// Controller state machine of the heap queue: sequences insert, pop and the sift loops.
// Depends on bmhq_pkg; drives the command struct of bmhq_dp.
module bmhq_ctrl import bmhq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	bmhq_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				if (stat.is_pop) begin
					if (stat.heap_empty || stat.single) state_nxt = S_FIN;
					else state_nxt = S_POP_RD;
				end else begin
					if (stat.full) state_nxt = S_FIN;
					else state_nxt = S_UP_RD;
				end
			end
			S_POP_RD: state_nxt = S_DN_RD;
			S_UP_RD: begin
				if (stat.at_root) state_nxt = S_FIN;
				else state_nxt = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (stat.up_swap) state_nxt = S_UP_RD;
				else state_nxt = S_FIN;
			end
			S_DN_RD: begin
				if (stat.down_leaf) state_nxt = S_FIN;
				else state_nxt = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (stat.down_move) state_nxt = S_DN_RD;
				else state_nxt = S_FIN;
			end
			S_FIN: begin
				if (!stat.out_busy) state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.accept = in_valid;
			end
			S_DECODE: begin
				if (stat.is_pop) begin
					if (stat.heap_empty) cmd.flag_empty = 1'b1;
					else cmd.pop_init = 1'b1;
				end else begin
					if (stat.full) cmd.flag_full = 1'b1;
					else cmd.ins_init = 1'b1;
				end
			end
			S_POP_RD: cmd.pop_load = 1'b1;
			S_UP_RD: begin
				if (stat.at_root) cmd.place = 1'b1;
				else cmd.up_read = 1'b1;
			end
			S_UP_CMP: begin
				if (stat.up_swap) cmd.up_step = 1'b1;
				else cmd.place = 1'b1;
			end
			S_DN_RD: begin
				if (stat.down_leaf) cmd.place = 1'b1;
				else cmd.down_read = 1'b1;
			end
			S_DN_CMP: begin
				if (stat.down_move) cmd.down_step = 1'b1;
				else cmd.place = 1'b1;
			end
			S_FIN: cmd.load_out = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// File: hw/rtl/bmhq_dp.sv
// Datapath of the heap queue: heap memory, moving entry, position, fill count and result word.
// Depends on bmhq_pkg; commanded by bmhq_ctrl.
module bmhq_dp import bmhq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic                  in_kind,
	input  logic [ID_BITS-1:0]    in_id,
	input  logic [KEY_BITS-1:0]   in_key,
	output logic                  out_valid,
	input  logic                  out_ready,
	output result_t               out_res,
	output status_t               out_status
);

	entry_t heap_mem_q [CAPACITY];
	entry_t rd0_q, rd1_q;

	logic                 kind_q;
	entry_t               e_q;
	logic [ADDR_BITS-1:0] pos_q;
	logic [CNT_BITS-1:0]  count_q;
	entry_t               root_q;
	entry_t               popped_q;
	status_t              status_q;
	logic                 out_valid_q;
	result_t              res_q;
	status_t              res_status_q;

	logic [CHILD_BITS-1:0] left_w, right_w, count_w;
	logic [ADDR_BITS-1:0]  pos_m1, parent_a, left_a, right_a;
	logic [CNT_BITS-1:0]   last_w;
	logic                  has_right, sel_l, sel_r;
	logic [KEY_BITS-1:0]   cmp_key;

	logic                  wr_en, rd0_en, rd1_en;
	logic [ADDR_BITS-1:0]  wr_addr, rd0_addr;
	entry_t                wr_data;

	assign left_w   = {1'b0, pos_q, 1'b1};
	assign right_w  = left_w + CHILD_BITS'(1);
	assign count_w  = {1'b0, count_q};
	assign left_a   = left_w[ADDR_BITS-1:0];
	assign right_a  = right_w[ADDR_BITS-1:0];
	assign pos_m1   = pos_q - ADDR_BITS'(1);
	assign parent_a = pos_m1 >> 1;
	assign last_w   = count_q - CNT_BITS'(1);

	// Down step: the left child is taken at or below the moving key, then the right
	// child wins at or below whichever key was chosen.
	assign has_right = right_w < count_w;
	assign sel_l     = e_q.key >= rd0_q.key;
	assign cmp_key   = sel_l ? rd0_q.key : e_q.key;
	assign sel_r     = has_right && (cmp_key >= rd1_q.key);

	always_comb begin
		stat.is_pop     = kind_q == KIND_POP;
		stat.heap_empty = count_q == '0;
		stat.single     = count_q == CNT_BITS'(1);
		stat.full       = count_q == CNT_BITS'(CAPACITY);
		stat.at_root    = pos_q == '0;
		stat.up_swap    = rd0_q.key >= e_q.key;
		stat.down_leaf  = left_w >= count_w;
		stat.down_move  = sel_l || sel_r;
		stat.out_busy   = out_valid_q && !out_ready;
	end

	always_comb begin
		wr_en    = cmd.up_step || cmd.down_step || cmd.place;
		wr_addr  = pos_q;
		wr_data  = e_q;
		if (cmd.up_step) wr_data = rd0_q;
		else if (cmd.down_step) wr_data = sel_r ? rd1_q : rd0_q;
		rd0_en   = cmd.pop_init || cmd.up_read || cmd.down_read;
		rd1_en   = cmd.down_read;
		rd0_addr = left_a;
		if (cmd.pop_init) rd0_addr = last_w[ADDR_BITS-1:0];
		else if (cmd.up_read) rd0_addr = parent_a;
	end

	always_ff @(posedge clk) begin
		if (wr_en) heap_mem_q[wr_addr] <= wr_data;
		if (rd0_en) rd0_q <= heap_mem_q[rd0_addr];
		if (rd1_en) rd1_q <= heap_mem_q[right_a];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= in_kind;
			e_q    <= '{key: in_key, id: in_id};
		end else if (cmd.pop_load) begin
			e_q <= rd0_q;
		end
		if (cmd.accept) begin
			popped_q <= '0;
			status_q <= ST_OK;
		end else if (cmd.flag_empty) begin
			status_q <= ST_EMPTY;
		end else if (cmd.flag_full) begin
			status_q <= ST_FULL;
		end else if (cmd.pop_init) begin
			popped_q <= root_q;
		end
		if (cmd.ins_init) pos_q <= count_q[ADDR_BITS-1:0];
		else if (cmd.pop_load) pos_q <= '0;
		else if (cmd.up_step) pos_q <= parent_a;
		else if (cmd.down_step) pos_q <= sel_r ? right_a : left_a;
		// The root copy follows every write to address zero.
		if (wr_en && wr_addr == '0) root_q <= wr_data;
		if (cmd.load_out) begin
			res_status_q         <= status_q;
			res_q.popped_id      <= popped_q.id;
			res_q.popped_key     <= popped_q.key;
			res_q.top_id         <= (count_q == '0) ? '0 : root_q.id;
			res_q.top_key        <= (count_q == '0) ? '0 : root_q.key;
			res_q.entry_count    <= count_q;
			res_q.is_empty       <= count_q == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins_init) count_q <= count_q + CNT_BITS'(1);
			else if (cmd.pop_init) count_q <= last_w;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_res    = res_q;
	assign out_status = res_status_q;

endmodule

// File: hw/rtl/binary_min_heap_queue_core.sv
// Top level of the binary min-heap priority queue: stream ports around controller and datapath.
// Depends on bmhq_pkg, bmhq_ctrl and bmhq_dp.
//
// Each input word is one operation (tuser 0 inserts the (key, id) pair in tdata, tuser 1 pops
// the minimum) and yields exactly one result word. Keys are unsigned 16.16 fixed point compared
// as integers; on ties an inserted entry rises past equal keys and a pop sifts down into a child
// whose key is at or below. The heap lives in a 4096-entry memory with one write and two
// registered read ports; each sift level is a read followed by a compare and write.
// An entry moves at most 12 levels for an insert into the last slot and 11 for a pop.
// Errors (pop on empty, insert on full) and the pop of the last entry skip the sift; errors
// leave the heap untouched. One operation is in work at a time; the next word is accepted while
// the previous result waits in the output register, and an operation that finishes while that
// register still holds an unread word waits until it is taken.
module binary_min_heap_queue_core import bmhq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// node_id [15:0], key [47:16]
	input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	// kind [0]
	input  logic                      s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// popped_id [15:0], popped_key [47:16], top_id [63:48], top_key [95:64],
	// entry_count [108:96], is_empty [109], zero fill [111:110]
	output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	// status [1:0]
	output logic [1:0]                m_axis_tuser
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	result_t  res;
	status_t  res_status;

	bmhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bmhq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_kind    (s_axis_tuser),
		.in_id      (s_axis_tdata[ID_BITS-1:0]),
		.in_key     (s_axis_tdata[ID_BITS+KEY_BITS-1:ID_BITS]),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res),
		.out_status (res_status)
	);

	assign m_axis_tdata = OUT_TDATA_BITS'(res);
	assign m_axis_tuser = res_status;

endmodule

// File: hw/rtl/bmhq_checker.sv
// Port-level checker of the heap queue, attached to the top level by the bind below.
// Depends on bmhq_pkg and the port list of binary_min_heap_queue_core.
module bmhq_checker import bmhq_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
	input logic                      s_axis_tuser,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
	input logic [1:0]                m_axis_tuser
);

	result_t    res;
	logic [1:0] pending_q;
	logic       in_acc, out_acc;

	assign res     = m_axis_tdata[RES_BITS-1:0];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Words accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 2'd0)
		else $error("result word shown with no input word outstanding");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more than two words outstanding");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> res.entry_count <= CNT_BITS'(CAPACITY))
		else $error("entry count beyond capacity");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (res.is_empty == (res.entry_count == '0)) &&
			(!res.is_empty || (res.top_key == '0 && res.top_id == '0)))
		else $error("empty flag or top fields disagree with the count");

	a_error_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |->
			(res.popped_key == '0 && res.popped_id == '0))
		else $error("failed operation reports a popped entry");

endmodule

bind binary_min_heap_queue_core bmhq_checker u_bmhq_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench for binary_min_heap_queue_core: a directed table, then random traffic,
// checked against a heap mirror kept in the bench, or against the typed result of a table row.
// Depends on bmhq_pkg and the RTL of the core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bmhq_pkg::*;

	localparam int  CYCLE_LIMIT = 3000000;
	localparam int  TAIL_CYCLES = 40;
	localparam int  RANDOM_OPS  = 380;

	typedef struct packed {
		status_t status;
		result_t res;
	} heap_result_t;

	typedef struct {
		logic               kind;
		logic [ID_BITS-1:0] id;
		logic [KEY_BITS-1:0] key;
		bit                 typed;
		heap_result_t       want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
	logic                      s_axis_tuser;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
	logic [1:0]                m_axis_tuser;

	binary_min_heap_queue_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	// Mirror of the heap contents, updated as each input word is accepted.
	logic [KEY_BITS-1:0] mirror_key [CAPACITY];
	logic [ID_BITS-1:0]  mirror_id  [CAPACITY];
	int unsigned         mirror_fill = 0;

	heap_result_t pending_results [$];
	int           mismatch_count = 0;
	int           cycle_count = 0;
	int           burst_left = 4;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [KEY_BITS-1:0] k;
		logic [ID_BITS-1:0]  d;
		k = mirror_key[a];
		d = mirror_id[a];
		mirror_key[a] = mirror_key[b];
		mirror_id[a]  = mirror_id[b];
		mirror_key[b] = k;
		mirror_id[b]  = d;
	endfunction

	// Ties rise: the new entry passes a parent with an equal key.
	function automatic void rise_from(int unsigned pos);
		int unsigned node;
		int unsigned parent;
		bit          done;
		node = pos;
		done = 0;
		while (node != 0 && !done) begin
			parent = (node - 1) / 2;
			if (mirror_key[parent] >= mirror_key[node]) begin
				swap_slots(parent, node);
				node = parent;
			end else begin
				done = 1;
			end
		end
	endfunction

	function automatic void sink_root(int unsigned n);
		int unsigned node;
		int unsigned pick;
		int unsigned lt;
		int unsigned rt;
		bit          done;
		node = 0;
		done = 0;
		while (!done) begin
			pick = node;
			lt = 2 * node + 1;
			rt = 2 * node + 2;
			if (rt < n) begin
				if (mirror_key[node] >= mirror_key[lt])
					pick = lt;
				if (mirror_key[pick] >= mirror_key[rt])
					pick = rt;
			end else if (lt < n) begin
				if (mirror_key[node] >= mirror_key[lt])
					pick = lt;
			end
			if (pick == node) begin
				done = 1;
			end else begin
				swap_slots(node, pick);
				node = pick;
			end
		end
	endfunction

	function automatic heap_result_t heap_apply(logic kind, logic [ID_BITS-1:0] id,
			logic [KEY_BITS-1:0] key);
		heap_result_t r;
		int unsigned  pos;
		r = '0;
		r.status = ST_OK;
		if (kind == KIND_INSERT) begin
			if (mirror_fill >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pos = mirror_fill;
				mirror_key[pos] = key;
				mirror_id[pos]  = id;
				mirror_fill = pos + 1;
				rise_from(pos);
			end
		end else begin
			if (mirror_fill == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.res.popped_key = mirror_key[0];
				r.res.popped_id  = mirror_id[0];
				mirror_fill = mirror_fill - 1;
				mirror_key[0] = mirror_key[mirror_fill];
				mirror_id[0]  = mirror_id[mirror_fill];
				sink_root(mirror_fill);
			end
		end
		if (mirror_fill != 0) begin
			r.res.top_key = mirror_key[0];
			r.res.top_id  = mirror_id[0];
		end
		r.res.entry_count = CNT_BITS'(mirror_fill);
		r.res.is_empty    = (mirror_fill == 0);
		return r;
	endfunction

	function automatic heap_result_t typed_result(status_t st, logic [ID_BITS-1:0] pid,
			logic [KEY_BITS-1:0] pkey, logic [ID_BITS-1:0] tid, logic [KEY_BITS-1:0] tkey,
			int unsigned cnt);
		heap_result_t r;
		r.status          = st;
		r.res.popped_id   = pid;
		r.res.popped_key  = pkey;
		r.res.top_id      = tid;
		r.res.top_key     = tkey;
		r.res.entry_count = CNT_BITS'(cnt);
		r.res.is_empty    = (cnt == 0);
		return r;
	endfunction

	function automatic stim_row_t directed_row(int idx);
		stim_row_t r;
		r.kind  = KIND_POP;
		r.id    = '0;
		r.key   = '0;
		r.typed = 0;
		r.want  = '0;
		case (idx)
			0: begin
				r.typed = 1;
				r.want  = typed_result(ST_EMPTY, '0, '0, '0, '0, 0);
			end
			1: begin
				r.kind  = KIND_INSERT;
				r.id    = 16'hFFFF;
				r.key   = 32'hFFFF_FFFF;
				r.typed = 1;
				r.want  = typed_result(ST_OK, '0, '0, 16'hFFFF, 32'hFFFF_FFFF, 1);
			end
			2: begin
				r.kind  = KIND_INSERT;
				r.typed = 1;
				r.want  = typed_result(ST_OK, '0, '0, '0, '0, 2);
			end
			3: begin
				// Equal key to the root, so the new entry takes its place.
				r.kind  = KIND_INSERT;
				r.id    = 16'h1234;
				r.typed = 1;
				r.want  = typed_result(ST_OK, '0, '0, 16'h1234, '0, 3);
			end
			4, 5, 6: ;
			7: begin
				// The data fields of a pop are ignored.
				r.id    = 16'hFFFF;
				r.key   = 32'hFFFF_FFFF;
				r.typed = 1;
				r.want  = typed_result(ST_EMPTY, '0, '0, '0, '0, 0);
			end
			8:  begin r.kind = KIND_INSERT; r.id = 16'hAAAA; r.key = 32'h5555_5555; end
			9:  begin r.kind = KIND_INSERT; r.id = 16'h5555; r.key = 32'hAAAA_AAAA; end
			10: begin r.kind = KIND_INSERT; r.id = 16'h0001; r.key = 32'h0001_0000; end
			11: begin r.kind = KIND_INSERT; r.id = 16'h0002; r.key = 32'h0001_0000; end
			12: begin r.kind = KIND_INSERT; r.id = 16'h0003; r.key = 32'h0001_0000; end
			13: begin r.kind = KIND_INSERT; r.id = 16'h0004; r.key = 32'h0000_0001; end
			14: begin r.kind = KIND_INSERT; r.id = 16'h0005; r.key = 32'hFFFF_FFFE; end
			15: begin r.id = 16'h5A5A; r.key = 32'hA5A5_5A5A; end
			16, 17, 18, 19, 20, 21: ;
			default: begin
				r.typed = 1;
				r.want  = typed_result(ST_EMPTY, '0, '0, '0, '0, 0);
			end
		endcase
		return r;
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 5)
			return $urandom;
		else if (sel < 8)
			return $urandom_range(0, 7);
		else if (sel == 8)
			return $urandom_range(0, 1) ? '1 : '0;
		else if ($urandom_range(0, 1))
			return KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1);
		else
			return ~(KEY_BITS'(1) << $urandom_range(0, KEY_BITS - 1));
	endfunction

	// Bursts of back-to-back words separated by random gaps; now and then a long burst.
	task automatic pace_sender();
		burst_left = burst_left - 1;
		if (burst_left <= 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			if ($urandom_range(0, 3) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(1, 16);
		end
	endtask

	task automatic send_op(logic kind, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key,
			bit typed, heap_result_t typed_want);
		heap_result_t want;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {key, id};
		do @(posedge clk); while (!s_axis_tready);
		want = heap_apply(kind, id, key);
		if (typed)
			want = typed_want;
		pending_results = {pending_results, want};
		pace_sender();
	endtask

	task automatic send_plain(logic kind, logic [ID_BITS-1:0] id, logic [KEY_BITS-1:0] key);
		send_op(kind, id, key, 0, '0);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(int count);
		int  pop_pct;
		logic kind;
		pop_pct = 25;
		for (int i = 0; i < count; i++) begin
			// Alternate growing and shrinking stretches so the heap also runs dry.
			if (i % 50 == 0)
				pop_pct = (pop_pct == 25) ? 70 : 25;
			kind = ($urandom_range(0, 99) < pop_pct) ? KIND_POP : KIND_INSERT;
			send_plain(kind, ID_BITS'($urandom), pick_key());
		end
	endtask

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	task automatic check_result();
		heap_result_t want;
		result_t      got;
		got = result_t'(m_axis_tdata[RES_BITS-1:0]);
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result word, expected none, actual tuser %0h tdata %0h",
				$time, m_axis_tuser, m_axis_tdata);
			mismatch_count++;
		end else begin
			want = pending_results.pop_front();
			compare_field("status", 64'(want.status), 64'(m_axis_tuser));
			compare_field("popped_id", 64'(want.res.popped_id), 64'(got.popped_id));
			compare_field("popped_key", 64'(want.res.popped_key), 64'(got.popped_key));
			compare_field("top_id", 64'(want.res.top_id), 64'(got.top_id));
			compare_field("top_key", 64'(want.res.top_key), 64'(got.top_key));
			compare_field("entry_count", 64'(want.res.entry_count), 64'(got.entry_count));
			compare_field("is_empty", 64'(want.res.is_empty), 64'(got.is_empty));
			compare_field("tdata fill", 64'h0, 64'(m_axis_tdata >> RES_BITS));
		end
	endtask

	// Receiver: modes of always ready, random ready and random stall runs.
	int rx_mode = 0;
	int rx_left = 0;
	int rx_hold = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				check_result();
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(32, 200);
			end
			rx_left = rx_left - 1;
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 9) < 6);
				default: begin
					if (rx_hold > 0) begin
						m_axis_tready <= 1'b0;
						rx_hold = rx_hold - 1;
					end else begin
						m_axis_tready <= 1'b1;
						if ($urandom_range(0, 3) == 0)
							rx_hold = $urandom_range(1, 16);
					end
				end
			endcase
		end
	end

	initial begin
		stim_row_t row;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 23; i++) begin
			row = directed_row(i);
			send_op(row.kind, row.id, row.key, row.typed, row.want);
		end
		wait_drained();

		run_random(RANDOM_OPS);
		wait_drained();

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: binary_min_heap_queue_core.f
hw/rtl/bmhq_pkg.sv
hw/rtl/bmhq_ctrl.sv
hw/rtl/bmhq_dp.sv
hw/rtl/binary_min_heap_queue_core.sv
hw/rtl/bmhq_checker.sv
verif/tb_top.sv
